>>> rtl/dsel_pkg.sv
// package: command, result codes, FSM states and beat structs for the deadline list
package dsel_pkg;
	localparam int ID_W = 8;
	localparam int TIME_W = 48;
	localparam int RATE_W = 16;
	localparam int CNT_W = 6;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_CHECK  = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ACK     = 2'd0,
		KIND_EXPIRED = 2'd1,
		KIND_NONE    = 2'd2,
		KIND_RSVD    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_RSVD     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INSERT,
		S_SCAN,
		S_MOVE,
		S_POP
	} state_t;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [ID_W-1:0]   entry_id;
		logic [TIME_W-1:0] emit_time;
		logic [RATE_W-1:0] rate_limit_ms;
		logic [TIME_W-1:0] now_time;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [ID_W-1:0]  out_id;
		logic [1:0]       status;
		logic [CNT_W-1:0] entries_left;
		logic             last;
	} out_beat_t;
endpackage

>>> rtl/deadline_sorted_expiry_list.sv
// top level: deadline-sorted expiry list held in one synchronous memory
//
// Keeps up to LIST_DEPTH (id, deadline) entries sorted by deadline in one
// memory with a registered read, used as a ring: a head pointer marks
// logical slot 0, so popping expired entries only moves the head. One
// command is in flight at a time; in_ready is high only in idle while the
// result register is free. A full insert, a remove on an empty list and a
// check on an empty list answer at once (result beat valid the next cycle).
// An insert walks from the tail, moving each entry later than the new one
// one slot back, then places the new entry. A remove reads from the head,
// searching slot by slot for the id, then moves each later entry forward.
// A check pops expired entries from the head until it sees the first live
// entry or the list runs empty; every expired beat but the first waits for
// the result register, so out_ready stalls stretch the check.
// Accesses of one command are strictly ordered, so no forwarding is needed.
// No clearing pass after reset: only data from occupied slots is ever used.
module deadline_sorted_expiry_list #(
	parameter int LIST_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dsel_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output dsel_pkg::out_beat_t out_data
);
	import dsel_pkg::*;

	localparam int AW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int ENT_W = TIME_W + ID_W;

	// logical slot to physical address, ring wraps at LIST_DEPTH
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] idx);
		logic [AW:0] s;
		s = {1'b0, hd} + (AW+1)'(idx);
		if (s >= (AW+1)'(LIST_DEPTH)) s = s - (AW+1)'(LIST_DEPTH);
		return s[AW-1:0];
	endfunction

	function automatic out_beat_t beat_of(input kind_t k, input logic [ID_W-1:0] id,
			input status_t st, input logic [CW-1:0] cnt, input logic fin);
		out_beat_t b;
		b.kind = k;
		b.out_id = id;
		b.status = st;
		b.entries_left = CNT_W'(cnt);
		b.last = fin;
		return b;
	endfunction

	// entry memory: deadline in upper bits, id in lower
	logic [ENT_W-1:0] mem [LIST_DEPTH];
	logic [ENT_W-1:0] rd_q;
	logic [AW-1:0]    raddr, waddr;
	logic             we;
	logic [ENT_W-1:0] wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	state_t state_q, state_d;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] dl_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     hd_q;
	// pos_q: logical walk pointer; phase_q: read issued, data arrives next cycle
	logic [CW-1:0]     pos_q;
	logic              phase_q;
	// popped_q: an expired beat sits in hold_q until we know if it is the last
	logic              popped_q;
	out_beat_t         hold_q;
	out_beat_t         obuf_q;
	logic              ovalid_q;

	// deadline saturates at the top of the time range
	logic [TIME_W:0]   sum;
	logic [TIME_W-1:0] dl_new;
	assign sum = {1'b0, in_data.emit_time} + (TIME_W+1)'(in_data.rate_limit_ms);
	assign dl_new = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

	logic [TIME_W-1:0] rd_dl;
	logic [ID_W-1:0]   rd_id;
	assign rd_dl = rd_q[ENT_W-1:ID_W];
	assign rd_id = rd_q[ID_W-1:0];

	logic [CW-1:0] pos_inc, pos_dec, cnt_inc, cnt_dec;
	logic [AW-1:0] hd_inc;
	assign pos_inc = pos_q + CW'(1);
	assign pos_dec = pos_q - CW'(1);
	assign cnt_inc = count_q + CW'(1);
	assign cnt_dec = count_q - CW'(1);
	assign hd_inc  = (hd_q == AW'(LIST_DEPTH - 1)) ? '0 : hd_q + AW'(1);

	// output register free when empty or being taken
	logic obuf_free;
	assign obuf_free = !ovalid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && obuf_free;
	assign out_valid = ovalid_q;
	assign out_data = obuf_q;

	logic in_fire;
	assign in_fire = in_valid && in_ready;

	logic full;
	assign full = (count_q >= CW'(LIST_DEPTH));

	// insert: entry read behind the walk point moves back when later than new one
	logic ins_shift, ins_done;
	assign ins_shift = (rd_dl > dl_q);
	assign ins_done = (pos_q == '0) || (phase_q && !ins_shift);

	// remove: search hit, end of list, end of the forward move
	logic id_hit, scan_end, move_done;
	assign id_hit = (rd_id == id_q);
	assign scan_end = (pos_inc == count_q);
	assign move_done = (pos_inc >= count_q);

	// check: decide on the head once its read is back, or at once when empty
	logic pop_decide, pop_hit, pop_take, pop_end;
	assign pop_decide = phase_q || (count_q == '0);
	assign pop_hit = (count_q != '0) && (rd_dl <= now_q);
	assign pop_take = pop_decide && pop_hit && (!popped_q || obuf_free);
	assign pop_end = pop_decide && !pop_hit && obuf_free;

	logic      emit;
	out_beat_t beat_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					case (cmd_t'(in_data.cmd))
						CMD_INSERT: if (!full) state_d = S_INSERT;
						CMD_REMOVE: if (count_q != '0) state_d = S_SCAN;
						CMD_CHECK:  if (count_q != '0) state_d = S_POP;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_INSERT: if (ins_done) state_d = S_IDLE;
			S_SCAN: begin
				if (phase_q) begin
					if (id_hit) state_d = S_MOVE;
					else if (scan_end) state_d = S_IDLE;
				end
			end
			S_MOVE: if (move_done) state_d = S_IDLE;
			S_POP: if (pop_end) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory port and result beat
	always_comb begin
		raddr  = '0;
		we     = 1'b0;
		waddr  = '0;
		wdata  = rd_q;
		emit   = 1'b0;
		beat_d = hold_q;
		case (state_q)
			S_IDLE: begin
				// answers that need no memory access
				if (in_fire) begin
					case (cmd_t'(in_data.cmd))
						CMD_INSERT: begin
							emit   = full;
							beat_d = beat_of(KIND_ACK, in_data.entry_id, ST_FULL, count_q, 1'b1);
						end
						CMD_REMOVE: begin
							emit   = (count_q == '0);
							beat_d = beat_of(KIND_ACK, in_data.entry_id, ST_NOTFOUND, count_q,
								1'b1);
						end
						CMD_CHECK: begin
							emit   = (count_q == '0);
							beat_d = beat_of(KIND_NONE, '0, ST_OK, count_q, 1'b1);
						end
						default: emit = 1'b0;
					endcase
				end
			end
			S_INSERT: begin
				raddr = (pos_q == '0) ? hd_q : phys(hd_q, pos_dec);
				if (pos_q == '0 || phase_q) begin
					we    = 1'b1;
					waddr = phys(hd_q, pos_q);
					wdata = (phase_q && ins_shift) ? rd_q : {dl_q, id_q};
				end
				emit   = ins_done;
				beat_d = beat_of(KIND_ACK, id_q, ST_OK, cnt_inc, 1'b1);
			end
			S_SCAN: begin
				raddr  = phys(hd_q, pos_q);
				emit   = phase_q && !id_hit && scan_end;
				beat_d = beat_of(KIND_ACK, id_q, ST_NOTFOUND, count_q, 1'b1);
			end
			S_MOVE: begin
				// pull slot pos_q+1 into pos_q up to the tail
				raddr = phys(hd_q, pos_inc);
				if (phase_q && !move_done) begin
					we    = 1'b1;
					waddr = phys(hd_q, pos_q);
					wdata = rd_q;
				end
				emit   = move_done;
				beat_d = beat_of(KIND_ACK, id_q, ST_OK, cnt_dec, 1'b1);
			end
			S_POP: begin
				// held expired beat goes out once the next head is known
				raddr = hd_q;
				emit  = (pop_take && popped_q) || pop_end;
				if (pop_end && !popped_q) beat_d = beat_of(KIND_NONE, '0, ST_OK, count_q, 1'b1);
				else beat_d.last = pop_end;
			end
			default: raddr = '0;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			hd_q     <= '0;
			pos_q    <= '0;
			phase_q  <= 1'b0;
			popped_q <= 1'b0;
			hold_q   <= '0;
			obuf_q   <= '0;
			ovalid_q <= 1'b0;
			id_q     <= '0;
			now_q    <= '0;
			dl_q     <= '0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				ovalid_q <= 1'b1;
				obuf_q   <= beat_d;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					phase_q  <= 1'b0;
					popped_q <= 1'b0;
					if (in_fire) begin
						id_q  <= in_data.entry_id;
						now_q <= in_data.now_time;
						dl_q  <= dl_new;
						// insert walks from the tail, the others from the head
						pos_q <= (cmd_t'(in_data.cmd) == CMD_INSERT) ? count_q : '0;
					end
				end
				S_INSERT: begin
					if (ins_done) begin
						count_q <= cnt_inc;
						phase_q <= 1'b0;
					end else if (!phase_q) begin
						phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						pos_q   <= pos_dec;
					end
				end
				S_SCAN: begin
					if (!phase_q) begin
						phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						if (!id_hit) pos_q <= pos_inc;
					end
				end
				S_MOVE: begin
					if (move_done) begin
						count_q <= cnt_dec;
					end else if (!phase_q) begin
						phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						pos_q   <= pos_inc;
					end
				end
				S_POP: begin
					// pop the head by moving the head pointer
					if (pop_take) begin
						hd_q     <= hd_inc;
						count_q  <= cnt_dec;
						hold_q   <= beat_of(KIND_EXPIRED, rd_id, ST_OK, cnt_dec, 1'b0);
						popped_q <= 1'b1;
						phase_q  <= 1'b0;
					end else if (!phase_q && count_q != '0) begin
						phase_q <= 1'b1;
					end
				end
				default: phase_q <= 1'b0;
			endcase
		end
	end
endmodule
